### sv/swrl_pkg.sv
package swrl_pkg;

    // action codes
    localparam logic [1:0] ACT_CHECK  = 2'd0;
    localparam logic [1:0] ACT_RECORD = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_MIN_INTERVAL = 2'd0;
    localparam logic [1:0] REG_MAX_ATTEMPTS = 2'd1;
    localparam logic [1:0] REG_WINDOW       = 2'd2;

    localparam int TIME_W  = 32;
    localparam int MS_W    = 24;
    localparam int MAXA_W  = 7;
    localparam int CNT_O_W = 7;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [MS_W-1:0]   MIN_INTERVAL_RST = 24'd15000;
    localparam logic [MAXA_W-1:0] MAX_ATTEMPTS_RST = 7'd25;
    localparam logic [MS_W-1:0]   WINDOW_RST       = 24'd60000;

    typedef logic [TIME_W-1:0] t_time;
    typedef logic [MS_W-1:0]   t_ms;

endpackage

### sv/sliding_window_rate_limiter_unit.sv
// Channel  | Handshake                | Payload
// ---------+--------------------------+-------------------------------------------
// input    | i_in_valid / o_in_ready  | i_action[1:0], i_now_ms[31:0]
// output   | o_out_valid / i_out_ready| o_allowed, o_attempts_in_window[6:0],
//          |                          | o_wait_ms[23:0]
// config   | APB psel/penable/pwrite  | paddr[3:0], pwdata/prdata[31:0]
//
// A clear, a too-soon check or an unused code goes from decode straight to the
// finish step. A check or record runs the expiry loop first, which stops when
// the ring is empty or expiry empties it, or at the first live entry. The
// expiry loop reads one stored time a cycle from the ring memory and runs it
// through the shared subtract/compare unit.
// Reset (synchronous, active low) empties the ring and restores the register
// defaults; the ring memory itself is never cleared, only counted.
// A result held on a stalled output blocks the end of the next item only.
module sliding_window_rate_limiter_unit #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input items
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_action,
    input  logic [31:0]                 i_now_ms,
    // results
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_allowed,
    output logic [6:0]                  o_attempts_in_window,
    output logic [23:0]                 o_wait_ms,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [swrl_pkg::ADDR_W-1:0] paddr,
    input  logic [swrl_pkg::DATA_W-1:0] pwdata,
    output logic [swrl_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int SW = CW + 1;

    // sequencer states
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DECODE  = 3'd1;
    localparam logic [2:0] ST_EXP_RD  = 3'd2;
    localparam logic [2:0] ST_EXP_CMP = 3'd3;
    localparam logic [2:0] ST_FINISH  = 3'd4;

    logic [2:0]                      r_state;
    logic [1:0]                      r_action;
    swrl_pkg::t_time                 r_now;
    logic                            r_chk_ok;
    logic [AW-1:0]                   r_oldest;
    logic [CW-1:0]                   r_count;
    swrl_pkg::t_time                 r_last_time;
    logic                            r_last_valid;
    swrl_pkg::t_ms                   r_min_interval;
    logic [swrl_pkg::MAXA_W-1:0]     r_max_attempts;
    swrl_pkg::t_ms                   r_window;
    logic                            r_out_valid;
    logic                            r_allowed;
    logic [swrl_pkg::CNT_O_W-1:0]    r_cnt_out;
    swrl_pkg::t_ms                   r_wait;

    // shared subtract/compare unit
    swrl_pkg::t_time                 cmp_opb;
    logic [swrl_pkg::MS_W:0]         cmp_thresh;
    swrl_pkg::t_time                 cmp_diff;
    logic                            cmp_lt;
    swrl_pkg::t_time                 wait_full;

    logic [AW-1:0]                   oldest_next;
    logic [SW-1:0]                   slot_sum;
    logic [AW-1:0]                   wr_slot;
    logic                            ring_full;
    logic [AW-1:0]                   rd_addr;
    swrl_pkg::t_time                 rd_data;
    logic                            wr_en;
    logic                            cfg_wr;
    logic                            out_free;

    assign cmp_opb    = (r_state == ST_EXP_CMP) ? rd_data : r_last_time;
    assign cmp_thresh = (r_state == ST_EXP_CMP) ? ({1'b0, r_window} + 25'd1)
                                                : {1'b0, r_min_interval};
    assign cmp_diff   = r_now - cmp_opb;
    assign cmp_lt     = cmp_diff < 32'(cmp_thresh);
    assign wait_full  = 32'(cmp_thresh) - cmp_diff;

    // ring pointer arithmetic
    assign oldest_next = (32'(r_oldest) == MAX_ENTRIES - 1) ? '0 : r_oldest + AW'(1);
    assign slot_sum    = SW'(r_oldest) + SW'(r_count);
    assign wr_slot     = (slot_sum >= SW'(MAX_ENTRIES)) ? AW'(slot_sum - SW'(MAX_ENTRIES))
                                                        : AW'(slot_sum);
    assign ring_full   = (r_count == CW'(MAX_ENTRIES));

    // when full, the oldest slot is overwritten and the oldest pointer moves on
    assign wr_en   = (r_state == ST_DECODE) && (r_action == swrl_pkg::ACT_RECORD);
    assign rd_addr = (r_state == ST_EXP_CMP) ? oldest_next : r_oldest;

    swrl_ram #(
        .WIDTH (swrl_pkg::TIME_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (ring_full ? r_oldest : wr_slot),
        .i_wdata (r_now),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign out_free = !r_out_valid || i_out_ready;
    assign cfg_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_oldest       <= '0;
            r_count        <= '0;
            r_last_time    <= '0;
            r_last_valid   <= 1'b0;
            r_chk_ok       <= 1'b0;
            r_out_valid    <= 1'b0;
            r_min_interval <= swrl_pkg::MIN_INTERVAL_RST;
            r_max_attempts <= swrl_pkg::MAX_ATTEMPTS_RST;
            r_window       <= swrl_pkg::WINDOW_RST;
        end else begin
            // configuration writes; unknown indexes are dropped
            if (cfg_wr) begin
                case (paddr[3:2])
                    swrl_pkg::REG_MIN_INTERVAL: r_min_interval <= pwdata[23:0];
                    swrl_pkg::REG_MAX_ATTEMPTS: r_max_attempts <= pwdata[6:0];
                    swrl_pkg::REG_WINDOW:       r_window       <= pwdata[23:0];
                    default: ;
                endcase
            end

            // drop a taken result; the finish step drives valid itself
            if (r_out_valid && i_out_ready && (r_state != ST_FINISH)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_action <= i_action;
                        r_now    <= i_now_ms;
                        r_state  <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    r_chk_ok <= 1'b0;
                    case (r_action)
                        swrl_pkg::ACT_CHECK: begin
                            // too soon: skip expiry and deny
                            if (r_last_valid && cmp_lt) begin
                                r_state <= ST_FINISH;
                            end else begin
                                r_chk_ok <= 1'b1;
                                r_state  <= ST_EXP_RD;
                            end
                        end
                        swrl_pkg::ACT_RECORD: begin
                            r_last_time  <= r_now;
                            r_last_valid <= 1'b1;
                            if (ring_full) begin
                                r_oldest <= oldest_next;
                            end else begin
                                r_count <= r_count + CW'(1);
                            end
                            r_state <= ST_EXP_RD;
                        end
                        swrl_pkg::ACT_CLEAR: begin
                            r_oldest     <= '0;
                            r_count      <= '0;
                            r_last_time  <= '0;
                            r_last_valid <= 1'b0;
                            r_state      <= ST_FINISH;
                        end
                        default: begin
                            r_state <= ST_FINISH;
                        end
                    endcase
                end
                ST_EXP_RD: begin
                    // read of the oldest slot is issued this cycle
                    r_state <= (r_count == '0) ? ST_FINISH : ST_EXP_CMP;
                end
                ST_EXP_CMP: begin
                    // expired when now - t > window, i.e. not below window + 1
                    if (!cmp_lt) begin
                        r_oldest <= oldest_next;
                        r_count  <= r_count - CW'(1);
                        if (r_count == CW'(1)) begin
                            r_state <= ST_FINISH;
                        end
                    end else begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_allowed   <= r_chk_ok &&
                                       (32'(r_count) < 32'(r_max_attempts));
                        r_cnt_out   <= (32'(r_count) > 32'd127) ? 7'd127
                                                                 : 7'(r_count);
                        r_wait      <= (r_last_valid && cmp_lt) ? wait_full[23:0]
                                                                : '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            swrl_pkg::REG_MIN_INTERVAL: prdata = 32'(r_min_interval);
            swrl_pkg::REG_MAX_ATTEMPTS: prdata = 32'(r_max_attempts);
            swrl_pkg::REG_WINDOW:       prdata = 32'(r_window);
            default:                    prdata = '0;
        endcase
    end

    assign pready               = 1'b1;
    assign o_in_ready           = (r_state == ST_IDLE);
    assign o_out_valid          = r_out_valid;
    assign o_allowed            = r_allowed;
    assign o_attempts_in_window = r_cnt_out;
    assign o_wait_ms            = r_wait;

endmodule

### sv/swrl_ram.sv
module swrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/swrl_chk.sv
module swrl_chk #(
    parameter int MAX_ENTRIES = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_allowed,
    input logic [6:0]  o_attempts_in_window,
    input logic [23:0] o_wait_ms
);

    // busy after taking an item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after an item was taken");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_allowed) &&
        $stable(o_attempts_in_window) && $stable(o_wait_ms))
        else $error("stalled result changed");

    // an allowed check implies the minimum interval has run out
    a_allowed_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_allowed |-> o_wait_ms == 24'd0)
        else $error("allowed with wait pending");

    // count never exceeds the ring size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_attempts_in_window) <= MAX_ENTRIES)
        else $error("count above ring size");

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind sliding_window_rate_limiter_unit swrl_chk #(
    .MAX_ENTRIES (MAX_ENTRIES)
) u_swrl_chk (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_in_valid),
    .o_in_ready           (o_in_ready),
    .o_out_valid          (o_out_valid),
    .i_out_ready          (i_out_ready),
    .o_allowed            (o_allowed),
    .o_attempts_in_window (o_attempts_in_window),
    .o_wait_ms            (o_wait_ms)
);

### test/sliding_window_rate_limiter_unit_test.sv
`timescale 1ns / 1ps

module sliding_window_rate_limiter_unit_test;

    localparam int          MAX_ENTRIES    = 64;
    // Spare action code and spare register slot; the block must ignore both.
    localparam logic [1:0]  ACT_UNUSED     = 2'd3;
    localparam logic [1:0]  REG_UNUSED     = 2'd3;
    // Idle time after the last result: one full expiry sweep plus margin.
    localparam int          SETTLE_CYCLES  = MAX_ENTRIES + 8;
    // Cycles without any handshake before the run is declared hung.
    localparam int          HANG_LIMIT     = 20000;
    localparam int unsigned RX_HOLD_CYCLES = 500;

    typedef struct packed {
        logic                         allowed;
        logic [swrl_pkg::CNT_O_W-1:0] count;
        swrl_pkg::t_ms                wait_ms;
    } t_verdict;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic [1:0]                    i_action;
    logic [31:0]                   i_now_ms;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic                          o_allowed;
    logic [6:0]                    o_attempts_in_window;
    logic [23:0]                   o_wait_ms;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [swrl_pkg::ADDR_W-1:0]   paddr;
    logic [swrl_pkg::DATA_W-1:0]   pwdata;
    logic [swrl_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    // Shadow of the limiter: attempt log, last attempt and the three limits.
    swrl_pkg::t_time               log_times [MAX_ENTRIES];
    int unsigned                   log_head         = 0;
    int unsigned                   log_count        = 0;
    swrl_pkg::t_time               last_time        = '0;
    bit                            last_seen        = 1'b0;
    swrl_pkg::t_ms                 cfg_min_gap      = swrl_pkg::MIN_INTERVAL_RST;
    logic [swrl_pkg::MAXA_W-1:0]   cfg_max_attempts = swrl_pkg::MAX_ATTEMPTS_RST;
    swrl_pkg::t_ms                 cfg_window       = swrl_pkg::WINDOW_RST;

    t_verdict                      expected_verdicts [$];
    int unsigned                   mismatch_count   = 0;
    swrl_pkg::t_time               sim_clock        = '0;

    // Traffic shaping knobs shared by the test tasks and the result sink.
    bit                            tx_steady        = 1'b0;
    bit                            rx_steady        = 1'b0;
    int unsigned                   rx_hold_cycles   = 0;

    sliding_window_rate_limiter_unit #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_action            (i_action),
        .i_now_ms            (i_now_ms),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_allowed           (o_allowed),
        .o_attempts_in_window(o_attempts_in_window),
        .o_wait_ms           (o_wait_ms),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Limiter shadow
    // ------------------------------------------------------------------

    // Drop every logged time older than the window; a time "in the future"
    // wraps to a huge distance and is dropped as well.
    function automatic void expire_log(swrl_pkg::t_time now);
        while (log_count > 0 &&
               swrl_pkg::t_time'(now - log_times[log_head]) >
               swrl_pkg::t_time'(cfg_window)) begin
            log_head  = (log_head + 1) % MAX_ENTRIES;
            log_count = log_count - 1;
        end
    endfunction

    function automatic swrl_pkg::t_ms wait_after(swrl_pkg::t_time now);
        swrl_pkg::t_time elapsed;
        elapsed = now - last_time;
        if (!last_seen || elapsed >= swrl_pkg::t_time'(cfg_min_gap))
            return '0;
        return cfg_min_gap - swrl_pkg::t_ms'(elapsed);
    endfunction

    // Advance the shadow by one item and return the verdict it must produce.
    function automatic t_verdict predict_verdict(logic [1:0] act, swrl_pkg::t_time now);
        t_verdict    v;
        int unsigned slot;
        v.allowed = 1'b0;
        case (act)
            swrl_pkg::ACT_CHECK: begin
                // A check that comes too soon leaves the log untouched.
                if (!(last_seen && swrl_pkg::t_time'(now - last_time) <
                                   swrl_pkg::t_time'(cfg_min_gap))) begin
                    expire_log(now);
                    v.allowed = (log_count < cfg_max_attempts);
                end
            end
            swrl_pkg::ACT_RECORD: begin
                last_time = now;
                last_seen = 1'b1;
                // Full ring: overwrite the oldest entry.
                if (log_count >= MAX_ENTRIES) begin
                    log_head  = (log_head + 1) % MAX_ENTRIES;
                    log_count = log_count - 1;
                end
                slot            = (log_head + log_count) % MAX_ENTRIES;
                log_times[slot] = now;
                log_count       = log_count + 1;
                expire_log(now);
            end
            swrl_pkg::ACT_CLEAR: begin
                log_head  = 0;
                log_count = 0;
                last_time = '0;
                last_seen = 1'b0;
            end
            default: begin
                // Spare code: no state change.
            end
        endcase
        v.count   = (log_count > 127) ? 7'd127 : 7'(log_count);
        v.wait_ms = wait_after(now);
        return v;
    endfunction

    function automatic logic [swrl_pkg::DATA_W-1:0] shadow_reg(logic [1:0] index);
        case (index)
            swrl_pkg::REG_MIN_INTERVAL: return swrl_pkg::DATA_W'(cfg_min_gap);
            swrl_pkg::REG_MAX_ATTEMPTS: return swrl_pkg::DATA_W'(cfg_max_attempts);
            swrl_pkg::REG_WINDOW:       return swrl_pkg::DATA_W'(cfg_window);
            default:                    return '0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly no gap, often a short one, rarely a long one.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Offer one item, hold it until accepted, then log its verdict.
    // Call on a falling edge; returns on a falling edge.
    task automatic send_item(input logic [1:0] act, input swrl_pkg::t_time now);
        int unsigned gap;
        i_action   = act;
        i_now_ms   = now;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_verdicts.insert(expected_verdicts.size(), predict_verdict(act, now));
        @(negedge i_clk);
        gap = tx_steady ? 0 : gap_len();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Drop valid, let every pending verdict arrive, then let the block settle.
    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (expected_verdicts.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One APB transfer: setup cycle, then access until pready.
    task automatic apb_access(input bit is_write, input logic [1:0] index,
                              input logic [swrl_pkg::DATA_W-1:0] wdata,
                              output logic [swrl_pkg::DATA_W-1:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = is_write;
        paddr   = {index, 2'b00};
        pwdata  = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        if (is_write) begin
            case (index)
                swrl_pkg::REG_MIN_INTERVAL: cfg_min_gap      = wdata[swrl_pkg::MS_W-1:0];
                swrl_pkg::REG_MAX_ATTEMPTS: cfg_max_attempts = wdata[swrl_pkg::MAXA_W-1:0];
                swrl_pkg::REG_WINDOW:       cfg_window       = wdata[swrl_pkg::MS_W-1:0];
                default: begin
                    // Spare slot: ignored by the block.
                end
            endcase
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_reg(input logic [1:0] index);
        logic [swrl_pkg::DATA_W-1:0] got;
        apb_access(1'b0, index, '0, got);
        if (got !== shadow_reg(index)) begin
            $display("%0t: register %0d expected %0h actual %0h",
                     $time, index, shadow_reg(index), got);
            mismatch_count++;
        end
    endtask

    // Write all three limits while the block is idle, with random junk in
    // the unused upper bits now and then, and read each one back.
    task automatic set_limits(input logic [swrl_pkg::DATA_W-1:0] min_gap,
                              input logic [swrl_pkg::DATA_W-1:0] max_attempts,
                              input logic [swrl_pkg::DATA_W-1:0] window);
        logic [swrl_pkg::DATA_W-1:0] junk;
        logic [swrl_pkg::DATA_W-1:0] unused;
        wait_idle();
        junk = $urandom_range(0, 1) ? $urandom : '0;
        apb_access(1'b1, swrl_pkg::REG_MIN_INTERVAL,
                   min_gap | (junk & 32'hFF00_0000), unused);
        check_reg(swrl_pkg::REG_MIN_INTERVAL);
        apb_access(1'b1, swrl_pkg::REG_MAX_ATTEMPTS,
                   max_attempts | (junk & 32'hFFFF_FF80), unused);
        check_reg(swrl_pkg::REG_MAX_ATTEMPTS);
        apb_access(1'b1, swrl_pkg::REG_WINDOW,
                   window | (junk & 32'hFF00_0000), unused);
        check_reg(swrl_pkg::REG_WINDOW);
    endtask

    // Advance the simulated millisecond clock and pick an action. Mostly
    // small forward steps, sometimes repeats, wild jumps or steps backwards.
    task automatic pick_item(input int unsigned step_max,
                             output logic [1:0] act, output swrl_pkg::t_time now);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            sim_clock = sim_clock + $urandom_range(0, step_max);
        else if (r < 94)
            sim_clock = $urandom;
        else if (r < 97)
            sim_clock = sim_clock - $urandom_range(1, step_max);
        now = sim_clock;
        r   = $urandom_range(0, 99);
        if (r < 50)
            act = swrl_pkg::ACT_RECORD;
        else if (r < 94)
            act = swrl_pkg::ACT_CHECK;
        else if (r < 97)
            act = swrl_pkg::ACT_CLEAR;
        else
            act = ACT_UNUSED;
    endtask

    task automatic run_random_items(input int unsigned n_items);
        logic [1:0]      act;
        swrl_pkg::t_time now;
        int unsigned     step_max;
        // Scale time steps to the larger of the two limits.
        step_max = ((cfg_window > cfg_min_gap) ? cfg_window : cfg_min_gap) / 6 + 1;
        repeat (n_items) begin
            pick_item(step_max, act, now);
            send_item(act, now);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset limits, wrap of the time counter, future times, spare code.
    task automatic test_reset_defaults();
        check_reg(swrl_pkg::REG_MIN_INTERVAL);
        check_reg(swrl_pkg::REG_MAX_ATTEMPTS);
        check_reg(swrl_pkg::REG_WINDOW);
        send_item(swrl_pkg::ACT_CHECK,  32'd1000);
        send_item(swrl_pkg::ACT_RECORD, 32'd1000);
        send_item(swrl_pkg::ACT_CHECK,  32'd5000);
        send_item(swrl_pkg::ACT_CHECK,  32'd16000);
        send_item(swrl_pkg::ACT_RECORD, 32'd16000);
        send_item(swrl_pkg::ACT_CHECK,  32'd80000);
        send_item(swrl_pkg::ACT_RECORD, 32'hFFFF_FFF0);
        send_item(swrl_pkg::ACT_CHECK,  32'h0000_0010);
        send_item(swrl_pkg::ACT_RECORD, 32'h0000_0010);
        send_item(swrl_pkg::ACT_RECORD, 32'h0000_0008);
        send_item(ACT_UNUSED,           32'h0000_0020);
        send_item(swrl_pkg::ACT_CLEAR,  32'h0000_0020);
        send_item(swrl_pkg::ACT_CHECK,  32'h0000_0021);
        wait_idle();
    endtask

    // Zero and full-scale limits, a limit of zero attempts and one above
    // the ring size, and a write to the spare register slot.
    task automatic test_limit_extremes();
        swrl_pkg::t_time             base;
        logic [swrl_pkg::DATA_W-1:0] unused;
        base = 32'h8000_0000;
        set_limits(32'd0, 32'd1, 32'd0);
        send_item(swrl_pkg::ACT_CLEAR,  base);
        send_item(swrl_pkg::ACT_RECORD, base);
        send_item(swrl_pkg::ACT_CHECK,  base);
        send_item(swrl_pkg::ACT_CHECK,  base + 1);
        send_item(swrl_pkg::ACT_RECORD, base + 1);
        send_item(swrl_pkg::ACT_RECORD, base + 1);
        send_item(swrl_pkg::ACT_CHECK,  base + 1);
        set_limits(32'h00FF_FFFF, 32'd0, 32'h00FF_FFFF);
        send_item(swrl_pkg::ACT_RECORD, base);
        send_item(swrl_pkg::ACT_CHECK,  base + 32'h00FF_FFFE);
        send_item(swrl_pkg::ACT_CHECK,  base + 32'h00FF_FFFF);
        send_item(ACT_UNUSED,           base + 5);
        wait_idle();
        apb_access(1'b1, REG_UNUSED, $urandom, unused);
        set_limits(32'h00FF_FFFF, 32'hFFFF_FFFF, 32'h00FF_FFFF);
        send_item(swrl_pkg::ACT_CHECK,  base + 32'h00FF_FFFF);
        wait_idle();
    endtask

    // Overfill the ring so it drops its oldest entries and its index wraps,
    // then jump past the window so one check expires the whole ring.
    task automatic test_ring_overflow();
        set_limits(32'd0, 32'd64, 32'h00FF_FFFF);
        sim_clock = $urandom;
        send_item(swrl_pkg::ACT_CLEAR, sim_clock);
        for (int i = 0; i < 80; i++) begin
            sim_clock = sim_clock + $urandom_range(0, 100);
            send_item((i % 8 == 7) ? swrl_pkg::ACT_CHECK : swrl_pkg::ACT_RECORD,
                      sim_clock);
        end
        sim_clock = sim_clock + 32'h0100_0000 + $urandom_range(0, 1000);
        send_item(swrl_pkg::ACT_CHECK, sim_clock);
        wait_idle();
    endtask

    // Random items under a sequence of random limit settings.
    task automatic test_random_limits();
        logic [swrl_pkg::DATA_W-1:0] min_gap;
        logic [swrl_pkg::DATA_W-1:0] max_attempts;
        logic [swrl_pkg::DATA_W-1:0] window;
        int unsigned                 r;
        for (int phase = 0; phase < 5; phase++) begin
            r = $urandom_range(0, 9);
            min_gap = (r == 0) ? 32'd0 : (r == 1) ? 32'h00FF_FFFF : $urandom_range(1, 2000);
            r = $urandom_range(0, 9);
            window = (r == 0) ? 32'd0 : (r == 1) ? 32'h00FF_FFFF : $urandom_range(100, 20000);
            r = $urandom_range(0, 9);
            max_attempts = (r == 0) ? 32'd0 : (r == 1) ? 32'd64 : (r == 2) ? 32'd127 :
                           $urandom_range(1, 12);
            set_limits(min_gap, max_attempts, window);
            run_random_items(60);
        end
        wait_idle();
    endtask

    // Hold the result side off for a long stretch while items keep coming,
    // pause until everything has drained, then run without any idling.
    task automatic test_output_backpressure();
        set_limits(32'd50, 32'd8, 32'd2000);
        tx_steady      = 1'b1;
        rx_hold_cycles = RX_HOLD_CYCLES;
        run_random_items(40);
        tx_steady = 1'b0;
        wait_idle();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        run_random_items(60);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Result sink: random ready, plus a long hold when a test asks for it
    // ------------------------------------------------------------------
    initial begin : result_sink
        int unsigned rx_gap;
        rx_gap      = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                i_out_ready    = 1'b0;
                rx_hold_cycles = rx_hold_cycles - 1;
            end else if (rx_gap > 0) begin
                i_out_ready = 1'b0;
                rx_gap      = rx_gap - 1;
            end else begin
                i_out_ready = 1'b1;
                if (!rx_steady)
                    rx_gap = gap_len();
            end
        end
    end

    // ------------------------------------------------------------------
    // Compare every accepted result with the oldest pending verdict
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : verdict_check
        t_verdict want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                         $time, o_allowed, o_attempts_in_window, o_wait_ms);
                mismatch_count++;
            end else begin
                want = expected_verdicts[0];
                expected_verdicts.delete(0);
                if (o_allowed !== want.allowed) begin
                    $display("%0t: allowed expected %0d actual %0d",
                             $time, want.allowed, o_allowed);
                    mismatch_count++;
                end
                if (o_attempts_in_window !== want.count) begin
                    $display("%0t: attempts_in_window expected %0d actual %0d",
                             $time, want.count, o_attempts_in_window);
                    mismatch_count++;
                end
                if (o_wait_ms !== want.wait_ms) begin
                    $display("%0t: wait_ms expected %0d actual %0d",
                             $time, want.wait_ms, o_wait_ms);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Hang detection: count cycles in which no handshake completes
    // ------------------------------------------------------------------
    initial begin : hang_watch
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (psel && penable))
                quiet = 0;
            else
                quiet = quiet + 1;
            if (quiet >= HANG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                         $time, quiet, expected_verdicts.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_action   = swrl_pkg::ACT_CHECK;
        i_now_ms   = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        // Hold reset, then release it away from the clock edge.
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_limit_extremes();
        test_ring_overflow();
        test_random_limits();
        test_output_backpressure();

        wait_idle();
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
